[hw/rtl/bpsa_pkg.sv]
`default_nettype none

package bpsa_pkg;

    localparam int CH_W      = 8;
    localparam int POS_W     = 16;
    localparam int DIM_W     = 9;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W    = 2;

    localparam logic [CH_W-1:0] CH_MAX = 8'hff;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PLOT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HAS_ALPHA    = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

endpackage

`default_nettype wire

[hw/rtl/bpsa_frame_mem.sv]
`default_nettype none

module bpsa_frame_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  wire logic              clk,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output bpsa_pkg::pixel_t       rd_data,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire bpsa_pkg::pixel_t  wr_data
);

    bpsa_pkg::pixel_t mem [DEPTH];
    bpsa_pkg::pixel_t rd_data_reg;

    // A read in the same cycle as a write to that entry returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/bpsa_rmw.sv]
`default_nettype none

module bpsa_rmw #(
    parameter int AW = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    input  wire logic [AW-1:0]     addr,
    input  wire bpsa_pkg::pixel_t  share,
    input  wire bpsa_pkg::pixel_t  rd_data,
    output logic                   wr_en,
    output logic [AW-1:0]          wr_addr,
    output bpsa_pkg::pixel_t       wr_data
);

    logic             last_valid_reg;
    logic [AW-1:0]    last_addr_reg;
    bpsa_pkg::pixel_t last_data_reg;
    bpsa_pkg::pixel_t base;
    bpsa_pkg::pixel_t sum;

    function automatic logic [bpsa_pkg::CH_W-1:0] sat_add(
        input logic [bpsa_pkg::CH_W-1:0] a,
        input logic [bpsa_pkg::CH_W-1:0] b
    );
        logic [bpsa_pkg::CH_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[bpsa_pkg::CH_W] ? bpsa_pkg::CH_MAX : s[bpsa_pkg::CH_W-1:0];
    endfunction

    // The read for this entry was issued while the previous update was being
    // written, so a hit on that address takes the freshly written value.
    always_comb
    begin
        base = (last_valid_reg && (last_addr_reg == addr)) ? last_data_reg : rd_data;
        sum.red   = sat_add(base.red,   share.red);
        sum.green = sat_add(base.green, share.green);
        sum.blue  = sat_add(base.blue,  share.blue);
    end

    assign wr_en   = valid;
    assign wr_addr = addr;
    assign wr_data = sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_valid_reg <= 1'b0;
        end
        else
        begin
            last_valid_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        last_addr_reg <= addr;
        last_data_reg <= sum;
    end

endmodule

`default_nettype wire

[hw/rtl/bilinear_point_splat_accumulator_unit.sv]
`default_nettype none

// Channel   Handshake               Payload
// input     in_valid / in_stall     kind, x_pos, y_pos, red_in, green_in, blue_in,
//                                   read_column, read_row
// result    out_valid / out_stall   status, red_out, green_out, blue_out, alpha_out
// config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A plot takes the transfer, PREP for weights and row bases, SPLAT that reads the
// four neighbors of the frame memory one by one, then write-back and result.
// A read goes via RD_ISSUE and RD_DATA; a rejected point or unknown kind goes to FINISH.
// A clear writes one pixel per cycle until all MAX_WIDTH*MAX_HEIGHT entries are zero.
// The frame memory is not cleared by reset; registers reset to 256, 256, 0.
// A result waits in the output register while out_stall is high; the next
// item is taken meanwhile and holds only when its own result finds it full.

module bilinear_point_splat_accumulator_unit #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [bpsa_pkg::KIND_W-1:0]        kind,
    input  wire logic [bpsa_pkg::POS_W-1:0]         x_pos,
    input  wire logic [bpsa_pkg::POS_W-1:0]         y_pos,
    input  wire logic [bpsa_pkg::CH_W-1:0]          red_in,
    input  wire logic [bpsa_pkg::CH_W-1:0]          green_in,
    input  wire logic [bpsa_pkg::CH_W-1:0]          blue_in,
    input  wire logic [bpsa_pkg::CH_W-1:0]          read_column,
    input  wire logic [bpsa_pkg::CH_W-1:0]          read_row,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    status,
    output logic [bpsa_pkg::CH_W-1:0]               red_out,
    output logic [bpsa_pkg::CH_W-1:0]               green_out,
    output logic [bpsa_pkg::CH_W-1:0]               blue_out,
    output logic [bpsa_pkg::CH_W-1:0]               alpha_out,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bpsa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [bpsa_pkg::DIM_W-1:0]         cfg_data
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int DIM_W  = bpsa_pkg::DIM_W;
    localparam int CH_W   = bpsa_pkg::CH_W;
    localparam int ROW_W  = 2 * DIM_W;
    localparam int WGT_W  = 2 * FRAC_BITS + 1;
    localparam int PROD_W = CH_W + WGT_W;
    localparam int CMP_W  = (DIM_W + FRAC_BITS > bpsa_pkg::POS_W) ?
                            DIM_W + FRAC_BITS : bpsa_pkg::POS_W;
    localparam logic [FRAC_BITS:0] ONE_FX = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_PREP     = 8'b0000_0010,
        ST_SPLAT    = 8'b0000_0100,
        ST_FLUSH    = 8'b0000_1000,
        ST_CLEAR    = 8'b0001_0000,
        ST_RD_ISSUE = 8'b0010_0000,
        ST_RD_DATA  = 8'b0100_0000,
        ST_FINISH   = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic             has_alpha_reg;
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;

    logic             in_accept;
    logic             plot_ok;
    logic             read_ok;
    logic [bpsa_pkg::POS_W:0] x_int;
    logic [bpsa_pkg::POS_W:0] y_int;
    logic [FRAC_BITS-1:0]     fx_in;
    logic [FRAC_BITS-1:0]     fy_in;

    logic [DIM_W-1:0]     x0_reg;
    logic [DIM_W-1:0]     x1_reg;
    logic [DIM_W-1:0]     y0_reg;
    logic [DIM_W-1:0]     y1_reg;
    logic [FRAC_BITS-1:0] fx_reg;
    logic [FRAC_BITS-1:0] fy_reg;
    bpsa_pkg::pixel_t     col_reg;
    logic [CH_W-1:0]      rc_reg;
    logic [CH_W-1:0]      rr_reg;

    logic [ROW_W-1:0]     row_reg [2];
    logic [WGT_W-1:0]     wgt_reg [4];
    logic [FRAC_BITS:0]   wx0;
    logic [FRAC_BITS:0]   wy0;
    logic [FRAC_BITS:0]   wx1;
    logic [FRAC_BITS:0]   wy1;

    logic [1:0]           n_reg;
    logic [AW-1:0]        clr_cnt_reg;

    logic [AW-1:0]        splat_addr;
    logic [AW-1:0]        read_addr;
    logic [WGT_W-1:0]     wgt_sel;
    logic [PROD_W-1:0]    prod_r;
    logic [PROD_W-1:0]    prod_g;
    logic [PROD_W-1:0]    prod_b;
    bpsa_pkg::pixel_t     share;

    logic                 sb_valid_reg;
    logic [AW-1:0]        sb_addr_reg;
    bpsa_pkg::pixel_t     share_reg;

    logic                 mem_rd_en;
    logic [AW-1:0]        mem_rd_addr;
    bpsa_pkg::pixel_t     mem_rd_data;
    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    bpsa_pkg::pixel_t     mem_wr_data;
    logic                 rmw_wr_en;
    logic [AW-1:0]        rmw_wr_addr;
    bpsa_pkg::pixel_t     rmw_wr_data;

    logic                 res_status_reg;
    bpsa_pkg::pixel_t     res_pix_reg;
    logic [CH_W-1:0]      res_alpha_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_status_reg;
    bpsa_pkg::pixel_t     out_pix_reg;
    logic [CH_W-1:0]      out_alpha_reg;
    logic                 out_free;
    logic                 out_load;

    // Sizes above the build maximum act as the maximum.
    assign w_eff = (int'(width_reg) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (int'(height_reg) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_reg;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign x_int = {1'b0, x_pos} >> FRAC_BITS;
    assign y_int = {1'b0, y_pos} >> FRAC_BITS;
    assign fx_in = x_pos[FRAC_BITS-1:0];
    assign fy_in = y_pos[FRAC_BITS-1:0];

    // A point must lie within the image as an exact fixed-point value, so the
    // far neighbor never leaves the image either.
    assign plot_ok = (w_eff != '0) && (h_eff != '0)
                  && (CMP_W'(x_pos) <= (CMP_W'(w_eff - DIM_W'(1)) << FRAC_BITS))
                  && (CMP_W'(y_pos) <= (CMP_W'(h_eff - DIM_W'(1)) << FRAC_BITS));
    assign read_ok = ({1'b0, read_column} < w_eff) && ({1'b0, read_row} < h_eff);

    assign wx1 = {1'b0, fx_reg};
    assign wy1 = {1'b0, fy_reg};
    assign wx0 = ONE_FX - wx1;
    assign wy0 = ONE_FX - wy1;

    // Neighbor order: near row near column, near row far column, far row near
    // column, far row far column.
    assign splat_addr = AW'(row_reg[n_reg[1]] + ROW_W'(n_reg[0] ? x1_reg : x0_reg));
    assign read_addr  = AW'(ROW_W'(rr_reg) * ROW_W'(w_eff) + ROW_W'(rc_reg));

    assign wgt_sel = wgt_reg[n_reg];
    assign prod_r  = PROD_W'(col_reg.red)   * PROD_W'(wgt_sel);
    assign prod_g  = PROD_W'(col_reg.green) * PROD_W'(wgt_sel);
    assign prod_b  = PROD_W'(col_reg.blue)  * PROD_W'(wgt_sel);
    assign share.red   = prod_r[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
    assign share.green = prod_g[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];
    assign share.blue  = prod_b[2*FRAC_BITS+CH_W-1:2*FRAC_BITS];

    assign mem_rd_en   = (state_reg == ST_SPLAT) || (state_reg == ST_RD_ISSUE);
    assign mem_rd_addr = (state_reg == ST_SPLAT) ? splat_addr : read_addr;

    assign mem_wr_en   = (state_reg == ST_CLEAR) || rmw_wr_en;
    assign mem_wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : rmw_wr_addr;
    assign mem_wr_data = (state_reg == ST_CLEAR) ? '0 : rmw_wr_data;

    assign out_free = !out_valid_reg || !out_stall;
    assign out_load = (state_reg == ST_FINISH) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    case (kind)
                        bpsa_pkg::KIND_CLEAR: state_next = ST_CLEAR;
                        bpsa_pkg::KIND_PLOT:  state_next = plot_ok ? ST_PREP : ST_FINISH;
                        bpsa_pkg::KIND_READ:  state_next = read_ok ? ST_RD_ISSUE : ST_FINISH;
                        default:              state_next = ST_FINISH;
                    endcase
                end
            end
            ST_PREP:     state_next = ST_SPLAT;
            ST_SPLAT:    state_next = (n_reg == 2'd3) ? ST_FLUSH : ST_SPLAT;
            ST_FLUSH:    state_next = ST_FINISH;
            ST_CLEAR:    state_next = (clr_cnt_reg == AW'(DEPTH - 1)) ? ST_FINISH : ST_CLEAR;
            ST_RD_ISSUE: state_next = ST_RD_DATA;
            ST_RD_DATA:  state_next = ST_FINISH;
            ST_FINISH:   state_next = out_free ? ST_IDLE : ST_FINISH;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            sb_valid_reg  <= 1'b0;
            n_reg         <= '0;
            clr_cnt_reg   <= '0;
            width_reg     <= DIM_W'(256);
            height_reg    <= DIM_W'(256);
            has_alpha_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            sb_valid_reg  <= (state_reg == ST_SPLAT);
            if (in_accept)
            begin
                n_reg       <= '0;
                clr_cnt_reg <= '0;
            end
            else
            begin
                if (state_reg == ST_SPLAT)
                begin
                    n_reg <= n_reg + 2'd1;
                end
                if (state_reg == ST_CLEAR)
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                end
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    bpsa_pkg::CFG_IMAGE_WIDTH:  width_reg     <= cfg_data;
                    bpsa_pkg::CFG_IMAGE_HEIGHT: height_reg    <= cfg_data;
                    bpsa_pkg::CFG_HAS_ALPHA:    has_alpha_reg <= cfg_data[0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            x0_reg        <= x_int[DIM_W-1:0];
            y0_reg        <= y_int[DIM_W-1:0];
            x1_reg        <= (fx_in != '0) ? x_int[DIM_W-1:0] + DIM_W'(1) : x_int[DIM_W-1:0];
            y1_reg        <= (fy_in != '0) ? y_int[DIM_W-1:0] + DIM_W'(1) : y_int[DIM_W-1:0];
            fx_reg        <= fx_in;
            fy_reg        <= fy_in;
            col_reg.red   <= red_in;
            col_reg.green <= green_in;
            col_reg.blue  <= blue_in;
            rc_reg        <= read_column;
            rr_reg        <= read_row;
            res_status_reg <= ((kind == bpsa_pkg::KIND_PLOT) && !plot_ok)
                           || ((kind == bpsa_pkg::KIND_READ) && !read_ok);
            res_pix_reg   <= '0;
            res_alpha_reg <= '0;
        end
        if (state_reg == ST_PREP)
        begin
            row_reg[0] <= ROW_W'(y0_reg) * ROW_W'(w_eff);
            row_reg[1] <= ROW_W'(y1_reg) * ROW_W'(w_eff);
            wgt_reg[0] <= WGT_W'(wx0) * WGT_W'(wy0);
            wgt_reg[1] <= WGT_W'(wx1) * WGT_W'(wy0);
            wgt_reg[2] <= WGT_W'(wx0) * WGT_W'(wy1);
            wgt_reg[3] <= WGT_W'(wx1) * WGT_W'(wy1);
        end
        sb_addr_reg <= splat_addr;
        share_reg   <= share;
        if (state_reg == ST_RD_DATA)
        begin
            res_pix_reg   <= mem_rd_data;
            res_alpha_reg <= has_alpha_reg ? bpsa_pkg::CH_MAX : '0;
        end
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_pix_reg    <= res_pix_reg;
            out_alpha_reg  <= res_alpha_reg;
        end
    end

    bpsa_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    bpsa_rmw #(
        .AW (AW)
    ) u_rmw (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (sb_valid_reg),
        .addr    (sb_addr_reg),
        .share   (share_reg),
        .rd_data (mem_rd_data),
        .wr_en   (rmw_wr_en),
        .wr_addr (rmw_wr_addr),
        .wr_data (rmw_wr_data)
    );

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign red_out   = out_pix_reg.red;
    assign green_out = out_pix_reg.green;
    assign blue_out  = out_pix_reg.blue;
    assign alpha_out = out_alpha_reg;

endmodule

`default_nettype wire

[sim/tb_bilinear_point_splat_accumulator_unit.sv]
`timescale 1ns / 100ps

module tb_bilinear_point_splat_accumulator_unit;

    import bpsa_pkg::*;

    localparam int MAX_W  = 256;
    localparam int MAX_H  = 256;
    localparam int FRAC   = 8;
    localparam int PIXELS = MAX_W * MAX_H;

    // The package names only the three real kinds; the fourth code yields an all-zero report.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  x_pos;
        logic [POS_W-1:0]  y_pos;
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [CH_W-1:0]   col;
        logic [CH_W-1:0]   row;
    } item_t;

    typedef struct packed {
        logic            status;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] alpha;
    } report_t;

    typedef enum logic [1:0] {STEP_PROBE, STEP_FIXED, STEP_GEOM} step_kind_t;

    typedef struct {
        step_kind_t       what;
        item_t            item;
        report_t          want;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [DIM_W-1:0] a;
    } step_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [KIND_W-1:0]    kind = '0;
    logic [POS_W-1:0]     x_pos = '0;
    logic [POS_W-1:0]     y_pos = '0;
    logic [CH_W-1:0]      red_in = '0;
    logic [CH_W-1:0]      green_in = '0;
    logic [CH_W-1:0]      blue_in = '0;
    logic [CH_W-1:0]      read_column = '0;
    logic [CH_W-1:0]      read_row = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 status;
    logic [CH_W-1:0]      red_out;
    logic [CH_W-1:0]      green_out;
    logic [CH_W-1:0]      blue_out;
    logic [CH_W-1:0]      alpha_out;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data = '0;

    // Our own copy of the registers and of the frame memory.
    logic [DIM_W-1:0]     img_width = 9'd256;
    logic [DIM_W-1:0]     img_height = 9'd256;
    logic                 img_alpha = 1'b0;
    logic [CH_W-1:0]      shade_mem [PIXELS][3];

    report_t              pending_reports [$];
    step_t                plan_q [$];
    bit                   idle_on = 1'b1;
    int                   hold_request = 0;
    int                   fault_count = 0;

    bilinear_point_splat_accumulator_unit i_dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #12_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic item_t mk_item(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] x,
                                      input logic [POS_W-1:0] y, input logic [CH_W-1:0] r,
                                      input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                                      input logic [CH_W-1:0] c, input logic [CH_W-1:0] rw);
        item_t it;
        it.kind  = k;
        it.x_pos = x;
        it.y_pos = y;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        it.col   = c;
        it.row   = rw;
        return it;
    endfunction

    function automatic report_t mk_report(input logic st, input logic [CH_W-1:0] r,
                                          input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                                          input logic [CH_W-1:0] a);
        return {st, r, g, b, a};
    endfunction

    function automatic void plan_probe(input item_t it);
        plan_q.push_back('{STEP_PROBE, it, '0, '0, '0, '0});
    endfunction

    function automatic void plan_fixed(input item_t it, input report_t want);
        plan_q.push_back('{STEP_FIXED, it, want, '0, '0, '0});
    endfunction

    function automatic void plan_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                          input logic [DIM_W-1:0] a);
        plan_q.push_back('{STEP_GEOM, '0, '0, w, h, a});
    endfunction

    // Applies one item to the frame copy and returns the report it should produce.
    function automatic report_t accumulate_item(input item_t it);
        report_t     rep;
        int unsigned ew, eh, x0, y0, x1, y1, fx, fy, sum, share;
        int unsigned wt [4];
        int unsigned idx [4];
        int unsigned colour [3];
        int          p, ch, k;
        rep = '0;
        ew = (img_width > MAX_W) ? MAX_W : img_width;
        eh = (img_height > MAX_H) ? MAX_H : img_height;
        case (it.kind)
            KIND_CLEAR:
            begin
                for (p = 0; p < PIXELS; p++)
                    for (ch = 0; ch < 3; ch++)
                        shade_mem[p][ch] = '0;
            end
            KIND_PLOT:
            begin
                if (ew == 0 || eh == 0 || it.x_pos > ((ew - 1) << FRAC) ||
                    it.y_pos > ((eh - 1) << FRAC))
                begin
                    rep.status = 1'b1;
                end
                else
                begin
                    x0 = it.x_pos >> FRAC;
                    y0 = it.y_pos >> FRAC;
                    fx = it.x_pos & ((1 << FRAC) - 1);
                    fy = it.y_pos & ((1 << FRAC) - 1);
                    x1 = (fx != 0) ? x0 + 1 : x0;
                    y1 = (fy != 0) ? y0 + 1 : y0;
                    wt[0] = ((1 << FRAC) - fx) * ((1 << FRAC) - fy);
                    wt[1] = fx * ((1 << FRAC) - fy);
                    wt[2] = ((1 << FRAC) - fx) * fy;
                    wt[3] = fx * fy;
                    idx[0] = y0 * ew + x0;
                    idx[1] = y0 * ew + x1;
                    idx[2] = y1 * ew + x0;
                    idx[3] = y1 * ew + x1;
                    colour[0] = it.red;
                    colour[1] = it.green;
                    colour[2] = it.blue;
                    for (ch = 0; ch < 3; ch++)
                        for (k = 0; k < 4; k++)
                            if (idx[k] < PIXELS)
                            begin
                                share = (colour[ch] * wt[k]) >> (2 * FRAC);
                                sum = shade_mem[idx[k]][ch] + share;
                                shade_mem[idx[k]][ch] = (sum > CH_MAX) ? CH_MAX : sum[CH_W-1:0];
                            end
                end
            end
            KIND_READ:
            begin
                if (it.col >= ew || it.row >= eh)
                begin
                    rep.status = 1'b1;
                end
                else
                begin
                    p = it.row * ew + it.col;
                    rep.red   = shade_mem[p][0];
                    rep.green = shade_mem[p][1];
                    rep.blue  = shade_mem[p][2];
                    rep.alpha = img_alpha ? CH_MAX : '0;
                end
            end
            default:
                rep = '0;
        endcase
        return rep;
    endfunction

    // Random item, mostly plots and reads around a small window of the image so that
    // reads find accumulated and saturated pixels; the rest is unconstrained noise.
    function automatic item_t draw_item(input int ew, input int eh, input int wc0,
                                        input int span_c, input int wr0, input int span_r);
        item_t it;
        int    roll, xi, yi, fx, fy;
        it = mk_item(KIND_UNUSED, POS_W'($urandom_range(0, 16'hffff)),
                     POS_W'($urandom_range(0, 16'hffff)), CH_W'($urandom_range(0, 255)),
                     CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                     CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)));
        roll = $urandom_range(0, 99);
        if (roll < 55)
        begin
            it.kind = KIND_PLOT;
            xi = $urandom_range(wc0, wc0 + span_c - 1);
            yi = $urandom_range(wr0, wr0 + span_r - 1);
            fx = ($urandom_range(0, 3) == 0 || xi == ew - 1) ? 0 : $urandom_range(0, 255);
            fy = ($urandom_range(0, 3) == 0 || yi == eh - 1) ? 0 : $urandom_range(0, 255);
            it.x_pos = {xi[7:0], fx[7:0]};
            it.y_pos = {yi[7:0], fy[7:0]};
            if ($urandom_range(0, 3) == 0)
            begin
                it.red   = CH_MAX;
                it.green = CH_MAX;
                it.blue  = CH_MAX;
            end
        end
        else if (roll < 85)
        begin
            it.kind = KIND_READ;
            xi = $urandom_range(wc0, wc0 + span_c);
            yi = $urandom_range(wr0, wr0 + span_r);
            it.col = (xi > 255) ? 8'hff : xi[7:0];
            it.row = (yi > 255) ? 8'hff : yi[7:0];
        end
        else if (roll < 93)
        begin
            it.kind = KIND_PLOT;
        end
        else if (roll < 97)
        begin
            it.kind = KIND_READ;
        end
        return it;
    endfunction

    task automatic send_item(input item_t it, input bit typed, input report_t want);
        int      gap;
        report_t forecast;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= it.kind;
        x_pos       <= it.x_pos;
        y_pos       <= it.y_pos;
        red_in      <= it.red;
        green_in    <= it.green;
        blue_in     <= it.blue;
        read_column <= it.col;
        read_row    <= it.row;
        do @(posedge clk); while (in_stall);
        forecast = accumulate_item(it);
        pending_reports.push_back(typed ? want : forecast);
    endtask

    // Every item yields exactly one report, so the block is idle once none is pending.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_geometry(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [DIM_W-1:0] a);
        logic [CFG_IDX_W-1:0] regs [3];
        logic [DIM_W-1:0]     vals [3];
        int                   k;
        regs = '{CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT, CFG_HAS_ALPHA};
        vals = '{w, h, a};
        cfg_valid <= 1'b1;
        for (k = 0; k < 3; k++)
        begin
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid  <= 1'b0;
        img_width  = w;
        img_height = h;
        img_alpha  = a[0];
    endtask

    initial
    begin : result_side
        int      hold;
        report_t got;
        report_t want;
        @(posedge rst_n);
        forever
        begin
            hold = idle_on ? $urandom_range(0, 4) : 0;
            if (hold_request != 0)
            begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got = {status, red_out, green_out, blue_out, alpha_out};
            if (pending_reports.size() == 0)
            begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: report with nothing pending: ",
                             "st=%0d rgb=%02h %02h %02h a=%02h",
                             $realtime, got.status, got.red, got.green, got.blue, got.alpha);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got.status !== want.status || got.red !== want.red ||
                    got.green !== want.green || got.blue !== want.blue ||
                    got.alpha !== want.alpha)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: mismatch: expected st=%0d rgb=%02h %02h %02h a=%02h, ",
                                 "got st=%0d rgb=%02h %02h %02h a=%02h",
                                 $realtime, want.status, want.red, want.green, want.blue,
                                 want.alpha, got.status, got.red, got.green, got.blue,
                                 got.alpha);
                end
            end
        end
    end

    initial
    begin : stimulus
        int               p, i, ew, eh, wc0, wr0, span_c, span_r, count;
        logic [DIM_W-1:0] w, h, a;

        // Directed part, first under the reset geometry of 256 x 256 without alpha.
        plan_fixed(mk_item(KIND_CLEAR, 0, 0, 0, 0, 0, 0, 0), mk_report(0, 0, 0, 0, 0));
        plan_fixed(mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0), mk_report(0, 0, 0, 0, 0));
        plan_fixed(mk_item(KIND_READ, 0, 0, 0, 0, 0, 8'hff, 8'hff), mk_report(0, 0, 0, 0, 0));
        plan_fixed(mk_item(KIND_PLOT, 0, 0, 8'hff, 8'hff, 8'hff, 0, 0),
                   mk_report(0, 0, 0, 0, 0));
        plan_fixed(mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0),
                   mk_report(0, 8'hff, 8'hff, 8'hff, 0));
        plan_fixed(mk_item(KIND_PLOT, 16'hff00, 16'hff00, 8'h12, 8'h34, 8'h56, 0, 0),
                   mk_report(0, 0, 0, 0, 0));
        plan_fixed(mk_item(KIND_READ, 0, 0, 0, 0, 0, 8'hff, 8'hff),
                   mk_report(0, 8'h12, 8'h34, 8'h56, 0));
        plan_fixed(mk_item(KIND_PLOT, 16'hffff, 0, 8'hff, 8'hff, 8'hff, 0, 0),
                   mk_report(1, 0, 0, 0, 0));
        plan_fixed(mk_item(KIND_PLOT, 0, 16'hff01, 8'hff, 8'hff, 8'hff, 0, 0),
                   mk_report(1, 0, 0, 0, 0));
        plan_probe(mk_item(KIND_PLOT, 16'h0180, 16'h0240, 8'hff, 8'h80, 8'h01, 0, 0));
        plan_probe(mk_item(KIND_READ, 0, 0, 0, 0, 0, 1, 2));
        plan_probe(mk_item(KIND_READ, 0, 0, 0, 0, 0, 2, 3));
        plan_probe(mk_item(KIND_PLOT, 16'h00ff, 16'h00ff, 8'hff, 8'hff, 8'hff, 0, 0));
        plan_probe(mk_item(KIND_PLOT, 16'h0180, 16'h0240, 8'hff, 8'hff, 8'hff, 0, 0));
        plan_probe(mk_item(KIND_READ, 0, 0, 0, 0, 0, 2, 2));
        plan_fixed(mk_item(KIND_UNUSED, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff),
                   mk_report(0, 0, 0, 0, 0));
        plan_fixed(mk_item(KIND_PLOT, 16'h1234, 16'h5678, 0, 0, 0, 0, 0),
                   mk_report(0, 0, 0, 0, 0));
        // A narrow image: the pitch changes, so earlier pixels show up elsewhere.
        plan_geometry(9'd4, 9'd3, 9'd1);
        plan_fixed(mk_item(KIND_READ, 0, 0, 0, 0, 0, 4, 0), mk_report(1, 0, 0, 0, 0));
        plan_fixed(mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 3), mk_report(1, 0, 0, 0, 0));
        plan_probe(mk_item(KIND_READ, 0, 0, 0, 0, 0, 3, 2));
        plan_fixed(mk_item(KIND_PLOT, 16'h0300, 16'h0200, 8'h10, 8'h20, 8'h30, 0, 0),
                   mk_report(0, 0, 0, 0, 0));
        plan_probe(mk_item(KIND_READ, 0, 0, 0, 0, 0, 3, 2));
        plan_fixed(mk_item(KIND_PLOT, 16'h0301, 0, 8'h10, 8'h20, 8'h30, 0, 0),
                   mk_report(1, 0, 0, 0, 0));
        plan_geometry(9'd0, 9'd3, 9'd1);
        plan_fixed(mk_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0), mk_report(1, 0, 0, 0, 0));
        plan_fixed(mk_item(KIND_PLOT, 0, 0, 8'hff, 8'hff, 8'hff, 0, 0),
                   mk_report(1, 0, 0, 0, 0));
        // Sizes above the maximum behave as the maximum.
        plan_geometry(9'd511, 9'd300, 9'd0);
        plan_fixed(mk_item(KIND_PLOT, 16'hff00, 16'hff00, 8'h01, 8'h02, 8'h03, 0, 0),
                   mk_report(0, 0, 0, 0, 0));
        plan_probe(mk_item(KIND_READ, 0, 0, 0, 0, 0, 8'hff, 8'hff));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < plan_q.size(); i++)
            case (plan_q[i].what)
                STEP_GEOM:
                begin
                    settle();
                    set_geometry(plan_q[i].w, plan_q[i].h, plan_q[i].a);
                end
                STEP_FIXED:
                    send_item(plan_q[i].item, 1'b1, plan_q[i].want);
                default:
                    send_item(plan_q[i].item, 1'b0, '0);
            endcase

        for (p = 0; p < 10; p++)
        begin
            case (p)
                0:
                begin
                    w = 9'd256;
                    h = 9'd256;
                    a = 9'd1;
                end
                1:
                begin
                    w = 9'd1;
                    h = 9'd1;
                    a = 9'd0;
                end
                2:
                begin
                    w = 9'd0;
                    h = DIM_W'($urandom_range(1, 511));
                    a = 9'd1;
                end
                3:
                begin
                    w = 9'd511;
                    h = 9'd300;
                    a = 9'h1ff;
                end
                4:
                begin
                    w = DIM_W'($urandom_range(2, 16));
                    h = 9'd0;
                    a = 9'h0fe;
                end
                5:
                begin
                    w = DIM_W'($urandom_range(2, 40));
                    h = DIM_W'($urandom_range(2, 40));
                    a = 9'd1;
                end
                6:
                begin
                    w = 9'd256;
                    h = DIM_W'($urandom_range(257, 511));
                    a = 9'd0;
                end
                default:
                begin
                    w = DIM_W'($urandom_range(1, 511));
                    h = DIM_W'($urandom_range(1, 511));
                    a = DIM_W'($urandom_range(0, 511));
                end
            endcase
            settle();
            set_geometry(w, h, a);
            idle_on = (p % 3 != 1);
            // Hold the result side off for a long stretch while items keep coming.
            if (p == 5)
                hold_request = 300;
            ew = (w > MAX_W) ? MAX_W : w;
            eh = (h > MAX_H) ? MAX_H : h;
            span_c = (ew == 0) ? 1 : ((ew < 6) ? ew : 6);
            span_r = (eh == 0) ? 1 : ((eh < 6) ? eh : 6);
            wc0 = (ew == 0) ? 0 : $urandom_range(0, ew - span_c);
            wr0 = (eh == 0) ? 0 : $urandom_range(0, eh - span_r);
            if (p == 0 || p == 3 || p == 7)
                send_item(mk_item(KIND_CLEAR, POS_W'($urandom_range(0, 16'hffff)),
                                  POS_W'($urandom_range(0, 16'hffff)),
                                  CH_W'($urandom_range(0, 255)),
                                  CH_W'($urandom_range(0, 255)),
                                  CH_W'($urandom_range(0, 255)),
                                  CH_W'($urandom_range(0, 255)),
                                  CH_W'($urandom_range(0, 255))),
                          1'b0, '0);
            count = (ew == 0 || eh == 0) ? 40 : 210;
            repeat (count)
                send_item(draw_item(ew, eh, wc0, span_c, wr0, span_r), 1'b0, '0);
        end

        settle();
        repeat (64) @(posedge clk);
        if (fault_count == 0 && pending_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
